FILE: rtl/core/timed_position_interpolator_top_defines.svh
// Assertion macros shared by the interpolator checker.
`ifndef TIMED_POSITION_INTERPOLATOR_TOP_DEFINES_SVH
`define TIMED_POSITION_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tpi checker: property failed");

// Next-cycle implication, disabled during reset.
`define TPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tpi checker: property failed");

// Next-cycle implication that also holds through reset.
`define TPI_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("tpi checker: reset property failed");

`endif

FILE: rtl/core/tpi_pkg.sv
// Types, codes and curve table function for the timed position interpolator.
package tpi_pkg;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ABS_GOAL = 2'd1,
        MODE_REL_GOAL = 2'd2,
        MODE_FORCE    = 2'd3
    } mode_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_CURVE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_ROM,
        ST_MUL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic rom_rd;
        logic mul;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic at_end;
        logic before_start;
        logic div_last;
        logic ease;
    } dp_status_t;

    // exp(-8*(1-u)^2) in Q1.16, u = idx / 2^tb. Evaluated at elaboration only.
    function automatic logic [16:0] curve_entry(input int unsigned idx,
                                                input int unsigned tb);
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        int k;
        int i;
        m = (64'd1 << tb) - 64'(idx);
        q = (m * m) << (30 - 2 * tb);
        r = 64'd1 << 31;
        for (k = 12; k >= 1; k--) begin
            r = (64'd1 << 31) - (((q * r) >> 31) / 64'(k));
        end
        for (i = 0; i < 4; i++) begin
            r = (r * r + (64'd1 << 30)) >> 31;
        end
        return 17'((r + (64'd1 << 14)) >> 15);
    endfunction

endpackage

FILE: rtl/core/tpi_datapath.sv
// Datapath: tween state, ratio divider, curve ROM, multiplier and commit logic.
module tpi_datapath import tpi_pkg::*; #(
    parameter int RATIO_BITS       = 16,
    parameter int CURVE_TABLE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic                  cfg_wdata,
    input  logic [1:0]            s_mode,
    input  logic [31:0]           s_time_ms,
    input  logic signed [31:0]    s_target_value,
    input  logic [31:0]           s_duration_ms,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic signed [31:0]    m_position,
    output logic                  m_finished
);

    localparam int FW = (RATIO_BITS > 17) ? RATIO_BITS : 17;
    localparam int PW = 34 + FW;
    localparam int CW = $clog2(RATIO_BITS);
    localparam int TD = 2 ** CURVE_TABLE_BITS;

    // latched transaction
    mode_t              mode_reg;
    logic [31:0]        time_reg;
    logic signed [31:0] target_reg;
    logic [31:0]        dur_reg;

    // tween state
    logic signed [31:0] cur_reg, cur_next;
    logic signed [31:0] start_reg, start_next;
    logic signed [31:0] goal_reg, goal_next;
    logic [31:0]        ws_reg, ws_next;
    logic [31:0]        we_reg, we_next;
    logic               done_reg, done_next;
    logic               ping_pong_reg;
    logic               ease_reg;

    // divider / multiplier
    logic [32:0]            rem_reg;
    logic [RATIO_BITS-1:0]  quo_reg;
    logic [CW-1:0]          cnt_reg;
    logic [16:0]            rom_q_reg;
    logic signed [PW-1:0]   prod_reg;

    logic signed [31:0] pos_out_reg;
    logic               fin_out_reg;

    logic [31:0]        el;
    logic [31:0]        win;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [CURVE_TABLE_BITS-1:0] rom_idx;
    logic [16:0]        curve_rom [TD];
    logic [FW-1:0]      factor;
    logic signed [32:0] delta;
    logic signed [PW-1:0] p_lin;
    logic signed [PW-1:0] p_ease;
    logic signed [31:0] interp;
    logic signed [32:0] rel_sum;
    logic signed [31:0] rel_sat;

    for (genvar g = 0; g < TD; g++) begin : g_rom
        assign curve_rom[g] = curve_entry(g, CURVE_TABLE_BITS);
    end

    if (RATIO_BITS >= CURVE_TABLE_BITS) begin : g_idx_trunc
        assign rom_idx = quo_reg[RATIO_BITS-1 -: CURVE_TABLE_BITS];
    end else begin : g_idx_shift
        assign rom_idx = {quo_reg, {(CURVE_TABLE_BITS - RATIO_BITS){1'b0}}};
    end

    assign el     = time_reg - ws_reg;
    assign win    = we_reg - ws_reg;
    assign rem_sh = {rem_reg[31:0], 1'b0};
    assign rem_ge = rem_sh >= {1'b0, win};

    assign factor = ease_reg ? FW'(rom_q_reg) : FW'(quo_reg);
    assign delta  = {goal_reg[31], goal_reg} - {start_reg[31], start_reg};
    assign p_lin  = prod_reg >>> RATIO_BITS;
    assign p_ease = prod_reg >>> 16;
    assign interp = start_reg + (ease_reg ? p_ease[31:0] : p_lin[31:0]);

    assign rel_sum = {target_reg[31], target_reg} + {cur_reg[31], cur_reg};
    always_comb begin
        if (rel_sum[32] != rel_sum[31]) begin
            rel_sat = rel_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            rel_sat = rel_sum[31:0];
        end
    end

    always_comb begin
        cur_next   = cur_reg;
        start_next = start_reg;
        goal_next  = goal_reg;
        ws_next    = ws_reg;
        we_next    = we_reg;
        done_next  = done_reg;
        unique case (mode_reg)
            MODE_TICK: begin
                if (status.at_end) begin
                    cur_next = goal_reg;
                    if (ping_pong_reg) begin
                        goal_next  = start_reg;
                        start_next = goal_reg;
                        we_next    = we_reg + (we_reg - ws_reg);
                        ws_next    = we_reg;
                    end else begin
                        done_next = 1'b1;
                    end
                end else begin
                    cur_next = interp;
                end
            end
            MODE_ABS_GOAL, MODE_REL_GOAL: begin
                start_next = cur_reg;
                goal_next  = (mode_reg == MODE_ABS_GOAL) ? target_reg : rel_sat;
                ws_next    = time_reg;
                we_next    = time_reg + dur_reg;
                done_next  = 1'b0;
            end
            MODE_FORCE: begin
                cur_next = target_reg;
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            start_reg     <= '0;
            goal_reg      <= '0;
            ws_reg        <= '0;
            we_reg        <= '0;
            done_reg      <= 1'b1;
            ping_pong_reg <= 1'b0;
            ease_reg      <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_PING_PONG) begin
                ping_pong_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_EASE_CURVE) begin
                ease_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                cur_reg   <= cur_next;
                start_reg <= start_next;
                goal_reg  <= goal_next;
                ws_reg    <= ws_next;
                we_reg    <= we_next;
                done_reg  <= done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= mode_t'(s_mode);
            time_reg   <= s_time_ms;
            target_reg <= s_target_value;
            dur_reg    <= s_duration_ms;
        end
        if (cmd.div_init) begin
            rem_reg <= {1'b0, el};
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, win}) : rem_sh;
            quo_reg <= {quo_reg[RATIO_BITS-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.rom_rd) begin
            rom_q_reg <= curve_rom[rom_idx];
        end
        if (cmd.mul) begin
            prod_reg <= PW'(delta * $signed({1'b0, factor}));
        end
        if (cmd.commit) begin
            pos_out_reg <= cur_next;
            fin_out_reg <= done_next;
        end
    end

    assign status.is_tick      = (mode_reg == MODE_TICK);
    assign status.at_end       = time_reg >= we_reg;
    assign status.before_start = time_reg < ws_reg;
    assign status.div_last     = (cnt_reg == CW'(RATIO_BITS - 1));
    assign status.ease         = ease_reg;

    assign m_position = pos_out_reg;
    assign m_finished = fin_out_reg;

endmodule

FILE: rtl/core/tpi_ctrl.sv
// Controller: sequences a transaction: divide, ROM, multiply as needed, commit.
module tpi_ctrl import tpi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_busy;

    assign out_busy = m_valid_reg && !m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (!status.is_tick || status.at_end) begin
                    state_next = ST_COMMIT;
                end else if (status.before_start) begin
                    state_next = status.ease ? ST_ROM : ST_MUL;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_last) state_next = status.ease ? ST_ROM : ST_MUL;
            end
            ST_ROM:    state_next = ST_MUL;
            ST_MUL:    state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (!out_busy) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DECODE: cmd.div_init = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_ROM:    cmd.rom_rd   = 1'b1;
            ST_MUL:    cmd.mul      = 1'b1;
            ST_COMMIT: cmd.commit   = !out_busy;
            default:   cmd          = '0;
        endcase
    end

    assign m_valid_next = cmd.commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/timed_position_interpolator_top.sv
// Top level of the timed position interpolator: controller plus datapath.
// Usage:
//   Input channel (s_valid/s_ready) carries one transaction per tick or command:
//   s_mode 0 tick, 1 absolute goal, 2 relative goal, 3 force position.
//   Result channel (m_valid/m_ready) returns one transaction per input:
//   m_position (signed Q16.16) and m_finished.
//   Config port: cfg_we with cfg_index 0 = ping_pong, 1 = ease_curve; write
//   only while the block is idle. Other indexes are ignored.
// Sequence:
//   Commands and end-of-window ticks go from decode straight to commit.
//   Ticks before the window start: multiply, then commit (curve ROM read first
//   in ease mode). Interpolating ticks: the restoring divider, one quotient bit
//   per cycle, forms the RATIO_BITS-bit ratio; then the curve ROM read in ease
//   mode, multiply and commit.
//   One transaction is in work at a time; the next can be accepted in the cycle
//   after the previous one has been placed in the output register.
// Reset: synchronous, active low; tween position 0, finished 1, both flags 0.
// Stall: a held result stays in the output register; a finished transaction
//   waits in its commit step until the output register frees up.
module timed_position_interpolator_top import tpi_pkg::*; #(
    parameter int RATIO_BITS       = 16,
    parameter int CURVE_TABLE_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [31:0]          s_time_ms,
    input  logic signed [31:0]   s_target_value,
    input  logic [31:0]          s_duration_ms,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_position,
    output logic                 m_finished
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: owns the handshakes and steps the datapath.
    tpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Tween state, divider, curve ROM, multiplier and output register.
    tpi_datapath #(
        .RATIO_BITS       (RATIO_BITS),
        .CURVE_TABLE_BITS (CURVE_TABLE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_mode         (s_mode),
        .s_time_ms      (s_time_ms),
        .s_target_value (s_target_value),
        .s_duration_ms  (s_duration_ms),
        .cmd            (cmd),
        .status         (status),
        .m_position     (m_position),
        .m_finished     (m_finished)
    );

endmodule

FILE: rtl/core/tpi_checker.sv
// Port-level checker for the interpolator, bound to the top level.
`include "timed_position_interpolator_top_defines.svh"
module tpi_checker import tpi_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic signed [31:0]   m_position,
    input logic                 m_finished
);

    // transactions accepted but not yet delivered
    logic [1:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc    = s_valid && s_ready;
    assign out_acc   = m_valid && m_ready;
    assign pend_next = pend_reg + 2'(in_acc) - 2'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `TPI_ASSERT_RST(a_reset_clears_out, !aresetn, !m_valid)
    `TPI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_position) && $stable(m_finished))
    `TPI_ASSERT_NOW(a_out_has_source, m_valid, pend_reg != 2'd0)
    `TPI_ASSERT_NOW(a_one_in_flight, in_acc, pend_reg == 2'd0 || (pend_reg == 2'd1 && m_valid))

endmodule

bind timed_position_interpolator_top tpi_checker u_tpi_checker (.*);

FILE: test/tb.sv
// Self-checking testbench for the timed position interpolator top level.
`timescale 1ns / 100ps

module tb;
    import tpi_pkg::*;

    typedef struct {
        logic signed [31:0] position;
        logic               finished;
    } tween_out_t;

    // Scoreboard: keeps its own copy of the tween state and predicts each result.
    class tween_scoreboard;
        logic               ping_pong_on;
        logic               ease_on;
        logic signed [31:0] cur_pos;
        logic signed [31:0] from_pos;
        logic signed [31:0] to_pos;
        logic [31:0]        win_begin;
        logic [31:0]        win_finish;
        logic               done;
        logic [16:0]        ease_lut [256];
        tween_out_t         pending_q [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            longint unsigned m, q, r;
            for (int i = 0; i < 256; i++) begin
                m = 256 - i;
                q = (m * m) << 14;
                r = 64'd1 << 31;
                for (int k = 12; k >= 1; k--) begin
                    r = (64'd1 << 31) - (((q * r) >> 31) / k);
                end
                for (int s = 0; s < 4; s++) begin
                    r = (r * r + (64'd1 << 30)) >> 31;
                end
                ease_lut[i] = 17'((r + (64'd1 << 14)) >> 15);
            end
            ping_pong_on = 0;
            ease_on      = 0;
            cur_pos      = 0;
            from_pos     = 0;
            to_pos       = 0;
            win_begin    = 0;
            win_finish   = 0;
            done         = 1;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
            if (idx == CFG_PING_PONG) begin
                ping_pong_on = val;
            end else if (idx == CFG_EASE_CURVE) begin
                ease_on = val;
            end
        endfunction

        function void start_window(logic signed [31:0] goal, logic [31:0] t, logic [31:0] dur);
            from_pos   = cur_pos;
            to_pos     = goal;
            win_begin  = t;
            win_finish = t + dur;
            done       = 0;
        endfunction

        function void advance(logic [31:0] t);
            longint            delta, p, ratio;
            logic signed [31:0] g;
            logic [31:0]        e;
            if (t >= win_finish) begin
                cur_pos = to_pos;
                if (ping_pong_on) begin
                    g          = to_pos;
                    e          = win_finish;
                    to_pos     = from_pos;
                    from_pos   = g;
                    win_finish = e + (e - win_begin);
                    win_begin  = e;
                end else begin
                    done = 1;
                end
                return;
            end
            ratio = 0;
            if (t >= win_begin) begin
                ratio = ({32'd0, 32'(t - win_begin)} << 16) / {32'd0, 32'(win_finish - win_begin)};
            end
            delta = longint'(to_pos) - longint'(from_pos);
            if (!ease_on) begin
                p = (delta * ratio) >>> 16;
            end else begin
                p = (delta * longint'({47'd0, ease_lut[ratio[15:8]]})) >>> 16;
            end
            cur_pos = 32'(longint'(from_pos) + p);
        endfunction

        // Called once per accepted input transaction.
        function void note_input(logic [1:0] mode, logic [31:0] t,
                                 logic signed [31:0] tgt, logic [31:0] dur);
            longint     sum;
            tween_out_t o;
            case (mode_t'(mode))
                MODE_TICK: begin
                    advance(t);
                end
                MODE_ABS_GOAL: begin
                    start_window(tgt, t, dur);
                end
                MODE_REL_GOAL: begin
                    sum = longint'(tgt) + longint'(cur_pos);
                    if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
                    if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
                    start_window(32'(sum), t, dur);
                end
                default: begin
                    cur_pos = tgt;
                end
            endcase
            o.position = cur_pos;
            o.finished = done;
            pending_q.push_back(o);
        endfunction

        // Called once per accepted result transaction.
        function void check_result(logic signed [31:0] pos, logic fin);
            tween_out_t o;
            results_seen++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual pos %h fin %b",
                         $time, pos, fin);
                mismatches++;
                return;
            end
            o = pending_q.pop_front();
            if (pos !== o.position) begin
                $display("%0t: position: expected %h, actual %h", $time, o.position, pos);
                mismatches++;
            end
            if (fin !== o.finished) begin
                $display("%0t: finished: expected %b, actual %b", $time, o.finished, fin);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic                 cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_mode;
    logic [31:0]          s_time_ms;
    logic signed [31:0]   s_target_value;
    logic [31:0]          s_duration_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [31:0]   m_position;
    logic                 m_finished;

    tween_scoreboard sb = new();

    // Idle percentages for the two sides; changed per phase.
    int          send_idle_pct;
    int          recv_stall_pct;
    int          sent_items;
    logic [31:0] clock_ms;

    timed_position_interpolator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_time_ms     (s_time_ms),
        .s_target_value(s_target_value),
        .s_duration_ms (s_duration_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_position    (m_position),
        .m_finished    (m_finished)
    );

    // 2 ns period.
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Result side: check every accepted transaction, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_position, m_finished);
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one transaction; valid is only dropped when a gap is taken, so it
    // never gets two assignments in one step.
    task automatic send_item(logic [1:0] mode, logic [31:0] t,
                             logic [31:0] tgt, logic [31:0] dur);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_time_ms      <= t;
        s_target_value <= tgt;
        s_duration_ms  <= dur;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_input(mode, t, tgt, dur);
        sent_items++;
    endtask

    // Wait until every expected result is back, then let the block settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_we    <= 1'b0;
    endtask

    // One goal command followed by ticks spread over its window, some before or past it.
    task automatic run_tween();
        logic [31:0] dur, tgt, t;
        logic [1:0]  mode;
        int          pick, n;
        longint      span;
        pick = $urandom_range(99);
        if (pick < 5) dur = 0;
        else if (pick < 75) dur = $urandom_range(1, 200);
        else if (pick < 90) dur = $urandom_range(1, 100000);
        else dur = $urandom;
        if ($urandom_range(9) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 1000);
        mode = ($urandom_range(1)) ? MODE_ABS_GOAL : MODE_REL_GOAL;
        tgt  = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
        send_item(mode, clock_ms, tgt, dur);
        n    = $urandom_range(1, 8);
        span = longint'(dur) * (sb.ping_pong_on ? 3 : 1) + dur / 4 + 2;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) t = clock_ms - $urandom_range(1, 50);
            else t = clock_ms + 32'(({$urandom, $urandom} % span));
            send_item(MODE_TICK, t, $urandom, $urandom);
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_PING_PONG;
        cfg_wdata      <= 1'b0;
        s_valid        <= 1'b0;
        s_mode         <= MODE_TICK;
        s_time_ms      <= 0;
        s_target_value <= 0;
        s_duration_ms  <= 0;
        m_ready        <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_items     = 0;
        clock_ms       = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset state, extremes, saturation, empty and wrapped windows.
        send_item(MODE_TICK,     32'd0,          32'd0,          32'd0);
        send_item(MODE_ABS_GOAL, 32'd100,        32'h7FFF_FFFF,  32'd1000);
        send_item(MODE_TICK,     32'd99,         32'd0,          32'd0);   // before start
        send_item(MODE_TICK,     32'd600,        32'd0,          32'd0);
        send_item(MODE_TICK,     32'd1100,       32'd0,          32'd0);   // window end
        send_item(MODE_TICK,     32'd5,          32'd0,          32'd0);   // after finish
        send_item(MODE_FORCE,    32'd0,          32'h8000_0000,  32'd0);
        send_item(MODE_REL_GOAL, 32'd10,         32'hFFFF_FFFF,  32'd50);  // low saturation
        send_item(MODE_TICK,     32'd30,         32'd0,          32'd0);
        send_item(MODE_FORCE,    32'hFFFF_FFFF,  32'h7FFF_FFFF,  32'hFFFF_FFFF);
        send_item(MODE_REL_GOAL, 32'd10,         32'd5,          32'd50);  // high saturation
        send_item(MODE_ABS_GOAL, 32'd2000,       32'd0,          32'd0);   // zero duration
        send_item(MODE_TICK,     32'd1999,       32'd0,          32'd0);
        send_item(MODE_TICK,     32'd2000,       32'd0,          32'd0);
        send_item(MODE_ABS_GOAL, 32'hFFFF_FF00,  32'd1234,       32'h200); // wrapped end
        send_item(MODE_TICK,     32'hFFFF_FF80,  32'd0,          32'd0);
        send_item(MODE_ABS_GOAL, 32'd10,         32'h8000_0000,  32'hFFFF_FFFF);
        send_item(MODE_TICK,     32'h8000_0000,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_item(MODE_TICK,     32'hFFFF_FFFF,  32'd0,          32'd0);
        wait_drained();   // sender holds off until every result is back
        write_cfg(2'd2, 1'b1);   // out-of-range index, ignored
        write_cfg(2'd3, 1'b1);

        // Random phases: every register setting, every idling mix.
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            write_cfg(CFG_PING_PONG,  ph[0]);
            write_cfg(CFG_EASE_CURVE, ph[1]);
            case ((ph + ph / 4) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < 135; ) begin
                if ($urandom_range(99) < 15) begin
                    send_item($urandom_range(3), $urandom, $urandom, $urandom);
                    n++;
                end else begin
                    run_tween();
                    n += 5;
                end
            end
        end

        wait_drained();
        $display("Sent %0d transactions and checked %0d results over all register",
                 sent_items, sb.results_seen);
        $display("settings and idle mixes; %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("Timeout: stimulus or results stuck.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/tpi_pkg.sv
rtl/core/tpi_datapath.sv
rtl/core/tpi_ctrl.sv
rtl/core/timed_position_interpolator_top.sv
rtl/core/tpi_checker.sv
test/tb.sv
